>>> rtl/core/rfam_pkg.sv
// Shared constants and types for the register file ALU machine.
// No dependencies; every other file in rtl/core refers to this package.
package rfam_pkg;

    // Register file geometry
    localparam int NUM_REGS  = 32;
    localparam int ADDR_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int REG_IDX_W = 5;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 4;
    localparam int STATUS_W  = 2;

    // Instruction kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_OUTPUT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_XCHG   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_ADD    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SUB    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_MUL    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_DIV    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_MOD    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_AND    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_OR     = 4'd10;
    localparam logic [KIND_W-1:0] KIND_XOR    = 4'd11;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HALTED  = 2'd3;

    // Register file read request (two ports, same cycle)
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr_a;
        logic [REG_IDX_W-1:0] addr_b;
    } rd_req_t;

    // Register file write request
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } wr_req_t;

    // Divider response
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

endpackage

>>> rtl/core/rfam_regfile.sv
// Register file: synchronous memory, two registered read ports, one write port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on rfam_pkg.
module rfam_regfile (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rfam_pkg::rd_req_t            rd_req,
    input  rfam_pkg::wr_req_t            wr_req,
    output logic [rfam_pkg::DATA_W-1:0]  rd_data_a,
    output logic [rfam_pkg::DATA_W-1:0]  rd_data_b
);

    logic [rfam_pkg::DATA_W-1:0]   mem [rfam_pkg::NUM_REGS];
    logic [rfam_pkg::NUM_REGS-1:0] valid_reg;
    logic [rfam_pkg::DATA_W-1:0]   data_a_reg;
    logic [rfam_pkg::DATA_W-1:0]   data_b_reg;
    logic                          hit_a_reg;
    logic                          hit_b_reg;
    logic                          in_rng_a;
    logic                          in_rng_b;
    logic                          in_rng_w;

    // Indexes at or above the register count read as zero and drop writes
    assign in_rng_a = 32'(rd_req.addr_a) < 32'(rfam_pkg::NUM_REGS);
    assign in_rng_b = 32'(rd_req.addr_b) < 32'(rfam_pkg::NUM_REGS);
    assign in_rng_w = 32'(wr_req.addr)   < 32'(rfam_pkg::NUM_REGS);

    always_ff @(posedge aclk) begin
        if (wr_req.en && in_rng_w) begin
            mem[wr_req.addr[rfam_pkg::ADDR_W-1:0]] <= wr_req.data;
        end
        if (rd_req.en) begin
            data_a_reg <= mem[rd_req.addr_a[rfam_pkg::ADDR_W-1:0]];
            data_b_reg <= mem[rd_req.addr_b[rfam_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end else begin
            if (wr_req.en && in_rng_w) begin
                valid_reg[wr_req.addr[rfam_pkg::ADDR_W-1:0]] <= 1'b1;
            end
            if (rd_req.en) begin
                hit_a_reg <= in_rng_a && valid_reg[rd_req.addr_a[rfam_pkg::ADDR_W-1:0]];
                hit_b_reg <= in_rng_b && valid_reg[rd_req.addr_b[rfam_pkg::ADDR_W-1:0]];
            end
        end
    end

    assign rd_data_a = hit_a_reg ? data_a_reg : '0;
    assign rd_data_b = hit_b_reg ? data_b_reg : '0;

endmodule

>>> rtl/core/rfam_divider.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on rfam_pkg.
module rfam_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rfam_pkg::DATA_W-1:0] dividend,
    input  logic [rfam_pkg::DATA_W-1:0] divisor,
    output rfam_pkg::div_rsp_t          div_rsp
);

    localparam int W   = rfam_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             run_reg;
    logic             fix_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic             neg_q_reg;
    logic             neg_r_reg;

    logic [W:0]       shifted;
    logic [W+1:0]     diff;
    logic [W-1:0]     abs_dend;
    logic [W-1:0]     abs_dvs;

    // Magnitudes; the most negative value maps onto 2^(W-1) unsigned
    assign abs_dend = dividend[W-1] ? (~dividend + 1'b1) : dividend;
    assign abs_dvs  = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;

    // Restoring step
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= fix_reg;
            fix_reg  <= 1'b0;
            if (start) begin
                run_reg   <= 1'b1;
                cnt_reg   <= '0;
                rem_reg   <= '0;
                quo_reg   <= abs_dend;
                dvs_reg   <= abs_dvs;
                neg_q_reg <= dividend[W-1] ^ divisor[W-1];
                neg_r_reg <= dividend[W-1];
            end else if (run_reg) begin
                if (!diff[W+1]) begin
                    rem_reg <= diff[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1)) begin
                    run_reg <= 1'b0;
                    fix_reg <= 1'b1;
                end
            end else if (fix_reg) begin
                // Quotient sign from both operands, remainder follows dividend
                if (neg_q_reg) begin
                    quo_reg <= ~quo_reg + 1'b1;
                end
                if (neg_r_reg) begin
                    rem_reg <= ~rem_reg + 1'b1;
                end
            end
        end
    end

    assign div_rsp.done      = done_reg;
    assign div_rsp.quotient  = quo_reg;
    assign div_rsp.remainder = rem_reg;

endmodule

>>> rtl/core/register_file_alu_machine.sv
// Top level of the register file ALU machine: control sequencer, ALU and output word register.
// Depends on rfam_pkg, rfam_regfile and rfam_divider.
//
// Executes one decoded instruction word at a time on a 32-entry file of 32-bit registers
// held in a synchronous memory (registered read, two read ports, one write port);
// the file reads as all zero after reset with no clearing pass, through per-entry valid bits.
// Each word has its operands read at the input handshake. For every kind but divide and
// modulo the execute state then computes the result, writes it back and loads it into the
// output register. Exchange loads its result in the execute state as well, but holds off
// the input while a further state writes the second register on the single write port.
// For divide and modulo the execute state starts the divider, which works out all 32 quotient
// bits in turn, fixes the signs and passes its done flag through a register; a write-back
// state then stores and emits the result. A new word is taken as
// soon as the previous one has written back, even while its result still waits in the output
// register; execution stalls only when the output register is full and not being drained.
// A divide or modulo by zero changes no register, reports status 2 and halts the machine:
// every later word is answered with status 3 until reset. out_value is zero except for output.
module register_file_alu_machine (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [rfam_pkg::KIND_W-1:0]            s_kind,
    input  logic [rfam_pkg::REG_IDX_W-1:0]         s_dest,
    input  logic [rfam_pkg::REG_IDX_W-1:0]         s_src_a,
    input  logic [rfam_pkg::REG_IDX_W-1:0]         s_src_b,
    input  logic                                   s_three_operand,
    input  logic signed [rfam_pkg::DATA_W-1:0]     s_immediate,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [rfam_pkg::STATUS_W-1:0]          m_status,
    output logic signed [rfam_pkg::DATA_W-1:0]     m_out_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_XCHG,
        S_DIV,
        S_DIVWB
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Captured instruction word
    logic [rfam_pkg::KIND_W-1:0]    kind_reg;
    logic [rfam_pkg::REG_IDX_W-1:0] dest_reg;
    logic [rfam_pkg::REG_IDX_W-1:0] src_a_reg;
    logic [rfam_pkg::DATA_W-1:0]    imm_reg;

    logic                           halted_reg;

    // Output word register
    logic                           m_valid_reg;
    logic [rfam_pkg::STATUS_W-1:0]  m_status_reg;
    logic [rfam_pkg::DATA_W-1:0]    m_out_value_reg;

    rfam_pkg::rd_req_t              rd_req;
    rfam_pkg::wr_req_t              wr_req;
    rfam_pkg::div_rsp_t             div_rsp;
    logic [rfam_pkg::DATA_W-1:0]    opnd_x;
    logic [rfam_pkg::DATA_W-1:0]    opnd_y;
    logic [rfam_pkg::DATA_W-1:0]    alu_res;
    logic                           sel_dest_a;
    logic                           accept;
    logic                           out_free;
    logic                           emit;
    logic [rfam_pkg::STATUS_W-1:0]  emit_status;
    logic [rfam_pkg::DATA_W-1:0]    emit_value;
    logic                           div_start;
    logic                           set_halt;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Operand fetch is issued in the accept cycle straight from the input word.
    // Port A carries dest and port B src_a for two-operand form and for
    // output / move / exchange; three-operand form reads src_a and src_b.
    assign sel_dest_a = !s_three_operand ||
                        (s_kind inside {rfam_pkg::KIND_OUTPUT, rfam_pkg::KIND_MOVE,
                                        rfam_pkg::KIND_XCHG});

    always_comb begin
        rd_req.en     = accept;
        rd_req.addr_a = sel_dest_a ? s_dest  : s_src_a;
        rd_req.addr_b = sel_dest_a ? s_src_a : s_src_b;
    end

    rfam_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_req    (rd_req),
        .wr_req    (wr_req),
        .rd_data_a (opnd_x),
        .rd_data_b (opnd_y)
    );

    rfam_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (opnd_x),
        .divisor  (opnd_y),
        .div_rsp  (div_rsp)
    );

    // Combinational ALU; sums and products wrap to 32 bits
    always_comb begin
        case (kind_reg)
            rfam_pkg::KIND_ADD: alu_res = opnd_x + opnd_y;
            rfam_pkg::KIND_SUB: alu_res = opnd_x - opnd_y;
            rfam_pkg::KIND_MUL: alu_res = opnd_x * opnd_y;
            rfam_pkg::KIND_AND: alu_res = opnd_x & opnd_y;
            rfam_pkg::KIND_OR:  alu_res = opnd_x | opnd_y;
            rfam_pkg::KIND_XOR: alu_res = opnd_x ^ opnd_y;
            default:            alu_res = '0;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        wr_req      = '0;
        emit        = 1'b0;
        emit_status = rfam_pkg::ST_DONE;
        emit_value  = '0;
        div_start   = 1'b0;
        set_halt    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // Read data holds until the next fetch, so stalling here is safe
                if (out_free) begin
                    state_next = S_IDLE;
                    emit       = 1'b1;
                    if (halted_reg) begin
                        emit_status = rfam_pkg::ST_HALTED;
                    end else begin
                        case (kind_reg)
                            rfam_pkg::KIND_LOAD: begin
                                wr_req.en   = 1'b1;
                                wr_req.addr = dest_reg;
                                wr_req.data = imm_reg;
                            end
                            rfam_pkg::KIND_OUTPUT: begin
                                emit_status = rfam_pkg::ST_OUT;
                                emit_value  = opnd_x;
                            end
                            rfam_pkg::KIND_MOVE: begin
                                wr_req.en   = 1'b1;
                                wr_req.addr = dest_reg;
                                wr_req.data = opnd_y;
                            end
                            rfam_pkg::KIND_XCHG: begin
                                wr_req.en   = 1'b1;
                                wr_req.addr = dest_reg;
                                wr_req.data = opnd_y;
                                state_next  = S_XCHG;
                            end
                            rfam_pkg::KIND_ADD, rfam_pkg::KIND_SUB, rfam_pkg::KIND_MUL,
                            rfam_pkg::KIND_AND, rfam_pkg::KIND_OR, rfam_pkg::KIND_XOR: begin
                                wr_req.en   = 1'b1;
                                wr_req.addr = dest_reg;
                                wr_req.data = alu_res;
                            end
                            rfam_pkg::KIND_DIV, rfam_pkg::KIND_MOD: begin
                                if (opnd_y == '0) begin
                                    set_halt    = 1'b1;
                                    emit_status = rfam_pkg::ST_DIVZERO;
                                end else begin
                                    emit       = 1'b0;
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                            end
                            default: begin
                                // unused kinds: no state change, status done
                            end
                        endcase
                    end
                end
            end
            S_XCHG: begin
                // second half of exchange: old dest value into src_a
                wr_req.en   = 1'b1;
                wr_req.addr = src_a_reg;
                wr_req.data = opnd_x;
                state_next  = S_IDLE;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_DIVWB;
                end
            end
            S_DIVWB: begin
                if (out_free) begin
                    wr_req.en   = 1'b1;
                    wr_req.addr = dest_reg;
                    wr_req.data = (kind_reg == rfam_pkg::KIND_DIV) ? div_rsp.quotient
                                                                   : div_rsp.remainder;
                    emit        = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (set_halt) begin
                halted_reg <= 1'b1;
            end
            if (emit) begin
                m_valid_reg     <= 1'b1;
                m_status_reg    <= emit_status;
                m_out_value_reg <= emit_value;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                kind_reg  <= s_kind;
                dest_reg  <= s_dest;
                src_a_reg <= s_src_a;
                imm_reg   <= s_immediate;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_value = m_out_value_reg;

endmodule

>>> rtl/core/rfam_checker.sv
// Port-level checker for the register file ALU machine, bound to the top level.
// Depends on rfam_pkg and register_file_alu_machine.
module rfam_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [rfam_pkg::STATUS_W-1:0]          m_status,
    input  logic signed [rfam_pkg::DATA_W-1:0]     m_out_value
);

    logic halt_seen_reg;

    // Set once a divide-by-zero word has been delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && (m_status == rfam_pkg::ST_DIVZERO)) begin
            halt_seen_reg <= 1'b1;
        end
    end

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_value))
        else $error("result word changed while stalled");

    // only an output instruction carries a value
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != rfam_pkg::ST_OUT) |-> (m_out_value == '0))
        else $error("nonzero value on non-output result");

    // after a halt every result reports ignored
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && halt_seen_reg |-> (m_status == rfam_pkg::ST_HALTED))
        else $error("result after halt not marked ignored");

    // one word in flight: input closes right after a take
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind register_file_alu_machine rfam_checker u_rfam_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for register_file_alu_machine: directed and random instruction words.
// Depends on rfam_pkg and the RTL under rtl/core; needs no files or arguments at run time.
// A shadow register file predicts each result word and a checker compares them in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [rfam_pkg::KIND_W-1:0]    kind_t;
    typedef logic [rfam_pkg::REG_IDX_W-1:0] reg_idx_t;
    typedef logic [rfam_pkg::DATA_W-1:0]    word_t;

    // Kinds past xor are decoded as no-ops
    localparam kind_t KIND_SPARE_FIRST = 4'd12;
    localparam kind_t KIND_SPARE_LAST  = 4'd15;

    localparam word_t WORD_MIN  = 32'h8000_0000;
    localparam word_t WORD_MAX  = 32'h7fff_ffff;
    localparam word_t WORD_ONES = 32'hffff_ffff;

    // Slowest legal run: ~500 words, each a divide plus the longest sender gap and the
    // longest sink stall; the limit leaves over ten times that.
    localparam int CYCLE_LIMIT  = 400_000;
    // Settle for longer than a divide or modulo takes from handshake to result.
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [rfam_pkg::STATUS_W-1:0] status;
        word_t                         value;
    } result_t;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    kind_t                               s_kind;
    reg_idx_t                            s_dest;
    reg_idx_t                            s_src_a;
    reg_idx_t                            s_src_b;
    logic                                s_three_operand;
    logic signed [rfam_pkg::DATA_W-1:0]  s_immediate;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [rfam_pkg::STATUS_W-1:0]       m_status;
    logic signed [rfam_pkg::DATA_W-1:0]  m_out_value;

    // Shadow of the machine state, updated when a word is accepted
    word_t shadow_file [rfam_pkg::NUM_REGS];
    bit    machine_halted;

    // Results owed by the block, oldest first
    result_t pending_results [$];

    // Idle controls for the two sides
    bit sender_gaps_on;
    bit sink_stalls_on;
    int stall_left;

    int words_sent;
    int words_halted;
    int results_checked;
    int mismatch_count;
    int cycle_count;

    register_file_alu_machine i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_dest          (s_dest),
        .s_src_a         (s_src_a),
        .s_src_b         (s_src_b),
        .s_three_operand (s_three_operand),
        .s_immediate     (s_immediate),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_value     (m_out_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts
    always @(posedge aclk) begin
        if (stall_left == 0 && sink_stalls_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 14);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Index outside the file reads as zero and ignores writes
    function automatic word_t file_read(input reg_idx_t idx);
        return (idx < rfam_pkg::NUM_REGS) ? shadow_file[idx] : '0;
    endfunction

    function automatic void file_write(input reg_idx_t idx, input word_t data);
        if (idx < rfam_pkg::NUM_REGS)
            shadow_file[idx] = data;
    endfunction

    // Execute one word on the shadow state and return the result it owes
    function automatic void execute_word(input kind_t kind,
                                         input reg_idx_t d, a, b,
                                         input logic three,
                                         input word_t imm,
                                         output result_t res);
        word_t  x, y, t;
        longint sx, sy;
        res.status = rfam_pkg::ST_DONE;
        res.value  = '0;
        if (machine_halted) begin
            res.status = rfam_pkg::ST_HALTED;
            words_halted++;
            return;
        end
        // left and right operands for the ALU forms
        x = three ? file_read(a) : file_read(d);
        y = three ? file_read(b) : file_read(a);
        case (kind)
            rfam_pkg::KIND_LOAD:   file_write(d, imm);
            rfam_pkg::KIND_OUTPUT: begin
                res.status = rfam_pkg::ST_OUT;
                res.value  = file_read(d);
            end
            rfam_pkg::KIND_MOVE:   file_write(d, file_read(a));
            rfam_pkg::KIND_XCHG: begin
                t = file_read(d);
                file_write(d, file_read(a));
                file_write(a, t);
            end
            rfam_pkg::KIND_ADD:    file_write(d, x + y);
            rfam_pkg::KIND_SUB:    file_write(d, x - y);
            rfam_pkg::KIND_MUL:    file_write(d, x * y);
            rfam_pkg::KIND_DIV, rfam_pkg::KIND_MOD: begin
                if (y == '0) begin
                    // zero divisor: nothing written, machine stops
                    machine_halted = 1'b1;
                    res.status     = rfam_pkg::ST_DIVZERO;
                end else begin
                    // 64-bit math keeps MIN / -1 exact; truncation gives MIN and 0
                    sx = longint'($signed(x));
                    sy = longint'($signed(y));
                    file_write(d, (kind == rfam_pkg::KIND_DIV) ? word_t'(sx / sy)
                                                               : word_t'(sx % sy));
                end
            end
            rfam_pkg::KIND_AND:    file_write(d, x & y);
            rfam_pkg::KIND_OR:     file_write(d, x | y);
            rfam_pkg::KIND_XOR:    file_write(d, x ^ y);
            default:               ;
        endcase
    endfunction

    function automatic void flag_mismatch(input string what, input longint want_v,
                                          input longint got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                     results_checked, what, want_v, got_v);
    endfunction

    // Result checker: every accepted result word against the oldest prediction
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                flag_mismatch("word with nothing owed, status", -1, m_status);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    flag_mismatch("status", want.status, m_status);
                if (m_out_value !== want.value)
                    flag_mismatch("out_value", $signed(want.value), m_out_value);
            end
        end
    end

    // Send one instruction word; predict its result at the handshake
    task automatic send_word(input kind_t kind,
                             input reg_idx_t d, a, b,
                             input logic three,
                             input word_t imm);
        result_t res;
        if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_dest          <= d;
        s_src_a         <= a;
        s_src_b         <= b;
        s_three_operand <= three;
        s_immediate     <= imm;
        do @(posedge aclk); while (!s_ready);
        execute_word(kind, d, a, b, three, imm, res);
        pending_results.push_back(res);
        words_sent++;
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Mostly a small working set so values flow between instructions
    function automatic reg_idx_t pick_reg();
        if ($urandom_range(0, 3) == 0)
            return reg_idx_t'($urandom_range(0, (1 << rfam_pkg::REG_IDX_W) - 1));
        return reg_idx_t'($urandom_range(0, 7));
    endfunction

    // Extremes on load, a never-written register, output
    task automatic test_load_and_output();
        send_word(rfam_pkg::KIND_LOAD, 5'd0, 5'd31, 5'd0, 1'b1, WORD_MIN);
        send_word(rfam_pkg::KIND_LOAD, 5'd1, 5'd0, 5'd31, 1'b0, WORD_MAX);
        send_word(rfam_pkg::KIND_LOAD, 5'd2, 5'd0, 5'd0, 1'b0, WORD_ONES);
        send_word(rfam_pkg::KIND_LOAD, 5'd3, 5'd0, 5'd0, 1'b0, 32'd7);
        send_word(rfam_pkg::KIND_OUTPUT, 5'd31, 5'd0, 5'd0, 1'b0, '0);   // still zero from reset
        send_word(rfam_pkg::KIND_OUTPUT, 5'd1, 5'd0, 5'd0, 1'b0, '0);
    endtask

    // dest op= src_a, with wrap at both ends
    task automatic test_two_operand_alu();
        send_word(rfam_pkg::KIND_ADD, 5'd1, 5'd3, 5'd0, 1'b0, '0);   // MAX + 7
        send_word(rfam_pkg::KIND_SUB, 5'd0, 5'd3, 5'd0, 1'b0, '0);   // MIN - 7
        send_word(rfam_pkg::KIND_MUL, 5'd2, 5'd1, 5'd0, 1'b0, '0);
        send_word(rfam_pkg::KIND_XOR, 5'd3, 5'd2, 5'd0, 1'b0, '0);
    endtask

    // dest = src_a op src_b
    task automatic test_three_operand_alu();
        send_word(rfam_pkg::KIND_AND, 5'd5, 5'd0, 5'd2, 1'b1, '0);
        send_word(rfam_pkg::KIND_OR, 5'd6, 5'd3, 5'd0, 1'b1, '0);
        send_word(rfam_pkg::KIND_MUL, 5'd7, 5'd5, 5'd6, 1'b1, '0);
        send_word(rfam_pkg::KIND_OUTPUT, 5'd7, 5'd0, 5'd0, 1'b0, '0);
    endtask

    // move, exchange, exchange of a register with itself
    task automatic test_move_exchange();
        send_word(rfam_pkg::KIND_MOVE, 5'd9, 5'd0, 5'd0, 1'b0, '0);
        send_word(rfam_pkg::KIND_XCHG, 5'd9, 5'd31, 5'd0, 1'b0, '0);
        send_word(rfam_pkg::KIND_XCHG, 5'd31, 5'd31, 5'd0, 1'b0, '0);
        send_word(rfam_pkg::KIND_OUTPUT, 5'd31, 5'd0, 5'd0, 1'b0, '0);
    endtask

    // MIN / -1, MIN % -1, and truncation of an inexact quotient of two negative operands
    task automatic test_divide_modulo();
        send_word(rfam_pkg::KIND_LOAD, 5'd10, 5'd0, 5'd0, 1'b0, WORD_MIN);
        send_word(rfam_pkg::KIND_LOAD, 5'd11, 5'd0, 5'd0, 1'b0, WORD_ONES);
        send_word(rfam_pkg::KIND_LOAD, 5'd14, 5'd0, 5'd0, 1'b0, -32'sd7);
        send_word(rfam_pkg::KIND_DIV, 5'd12, 5'd10, 5'd11, 1'b1, '0);
        send_word(rfam_pkg::KIND_MOD, 5'd13, 5'd10, 5'd11, 1'b1, '0);
        send_word(rfam_pkg::KIND_DIV, 5'd10, 5'd14, 5'd0, 1'b0, '0);
        send_word(rfam_pkg::KIND_OUTPUT, 5'd12, 5'd0, 5'd0, 1'b0, '0);
    endtask

    task automatic test_unused_kinds();
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            send_word(kind_t'(k), pick_reg(), pick_reg(), pick_reg(), k[0], $urandom);
    endtask

    // Random program; quiet runs it with no idling on either side
    task automatic test_random_program(input int count, input bit quiet);
        kind_t    kind;
        reg_idx_t d, a, b;
        logic     three;
        word_t    imm;
        int       pick, mode;
        sender_gaps_on = !quiet;
        sink_stalls_on = !quiet;
        for (int i = 0; i < count; i++) begin
            // new idle mix every 50 words, including stretches with none
            if (!quiet && i % 50 == 0) begin
                mode           = $urandom_range(0, 3);
                sender_gaps_on = mode[0];
                sink_stalls_on = mode[1];
            end
            if (!quiet && i == count / 2)
                drain_results();
            d     = pick_reg();
            a     = pick_reg();
            b     = pick_reg();
            three = 1'($urandom_range(0, 1));
            imm   = $urandom;
            pick  = $urandom_range(0, 99);
            if (pick < 12) begin
                kind = rfam_pkg::KIND_LOAD;
                // half the loads seed edge values so MIN / -1 and wraps come up
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 5))
                        0: imm = WORD_MIN;
                        1: imm = WORD_MAX;
                        2: imm = WORD_ONES;
                        3: imm = '0;
                        4: imm = $urandom_range(1, 16);
                        default: imm = -word_t'($urandom_range(1, 16));
                    endcase
                end
            end else if (pick < 22) begin
                kind = rfam_pkg::KIND_OUTPUT;
            end else if (pick < 27) begin
                kind = rfam_pkg::KIND_MOVE;
            end else if (pick < 32) begin
                kind = rfam_pkg::KIND_XCHG;
            end else if (pick < 96) begin
                kind = kind_t'($urandom_range(rfam_pkg::KIND_ADD, rfam_pkg::KIND_XOR));
            end else begin
                kind = kind_t'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
            end
            // a zero divisor would halt for good; save that for the end
            if ((kind == rfam_pkg::KIND_DIV || kind == rfam_pkg::KIND_MOD) &&
                file_read(three ? b : a) == '0)
                kind = rfam_pkg::KIND_OR;
            send_word(kind, d, a, b, three, imm);
        end
    endtask

    // Zero divisor halts; everything after answers ignored with zero value
    task automatic test_halt_on_zero_divisor();
        send_word(rfam_pkg::KIND_LOAD, 5'd20, 5'd0, 5'd0, 1'b0, '0);
        send_word(rfam_pkg::KIND_LOAD, 5'd21, 5'd0, 5'd0, 1'b0, 32'd12345);
        send_word(rfam_pkg::KIND_DIV, 5'd21, 5'd20, 5'd0, 1'b0, '0);
        send_word(rfam_pkg::KIND_OUTPUT, 5'd21, 5'd0, 5'd0, 1'b0, '0);
        send_word(rfam_pkg::KIND_LOAD, 5'd22, 5'd0, 5'd0, 1'b0, WORD_MAX);
        send_word(rfam_pkg::KIND_MOD, 5'd21, 5'd20, 5'd20, 1'b1, '0);
        send_word(rfam_pkg::KIND_ADD, 5'd1, 5'd2, 5'd3, 1'b1, '0);
        send_word(KIND_SPARE_LAST, 5'd0, 5'd0, 5'd0, 1'b0, '0);
        send_word(rfam_pkg::KIND_OUTPUT, 5'd22, 5'd0, 5'd0, 1'b0, '0);
    endtask

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_kind          <= rfam_pkg::KIND_LOAD;
        s_dest          <= '0;
        s_src_a         <= '0;
        s_src_b         <= '0;
        s_three_operand <= 1'b0;
        s_immediate     <= '0;
        for (int i = 0; i < rfam_pkg::NUM_REGS; i++)
            shadow_file[i] = '0;
        machine_halted = 1'b0;
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_load_and_output();
        test_two_operand_alu();
        test_three_operand_alu();
        test_move_exchange();
        test_divide_modulo();
        test_unused_kinds();
        test_random_program(440, 1'b0);
        // last part: no idling on either side
        test_random_program(30, 1'b1);
        test_halt_on_zero_divisor();

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d words: all kinds in both forms, edge values, idle and stall bursts,",
                 words_sent);
        $display("then a zero divisor halt with %0d words ignored; %0d results, %0d mismatches",
                 words_halted, results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
